@@ rtl/pairwise_capture_check_macros.svh @@
// Assertion macros shared by the RTL
`ifndef PAIRWISE_CAPTURE_CHECK_MACROS_SVH
`define PAIRWISE_CAPTURE_CHECK_MACROS_SVH
// implication checked on every clock edge outside reset
`define PCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("%m: label failed");
// next-cycle implication
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("%m: label failed");
`endif

@@ rtl/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the pairwise capture check.
// ----------------------------------------------------------------------------
package pcc_pkg;
	localparam int CELLS = 128;
	localparam int BEADS = 128;
	localparam int CW = $clog2(CELLS);
	localparam int BW = $clog2(BEADS);
	localparam int IDXW = 7;
	localparam logic [62:0] DIST_SQ_RESET = 63'd966367641600;

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_LOAD_CELL = 3'd1,
		OP_LOAD_BEAD = 3'd2,
		OP_MOVE_CELL = 3'd3,
		OP_MOVE_BEAD = 3'd4,
		OP_CHECK = 3'd5
	} opcode_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [IDXW-1:0] index;
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
	} cmd_t;

	typedef struct packed {
		logic [7:0] captured_beads;
		logic [7:0] beads_with_one;
		logic [7:0] beads_with_two;
		logic [7:0] beads_with_three;
		logic [7:0] beads_with_four;
	} rsp_t;

	// saturating 32-bit signed add
	function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
		logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		return s[31:0];
	endfunction

	// saturating 8-bit increment
	function automatic logic [7:0] sat_inc(logic [7:0] v);
		return (v == 8'hff) ? v : v + 8'd1;
	endfunction
endpackage

@@ rtl/pcc_cmd_if.sv @@
// ----------------------------------------------------------------------------
// pcc_cmd_if / pcc_rsp_if
// Valid-ready channels carrying command and result beats.
// ----------------------------------------------------------------------------
interface pcc_cmd_if import pcc_pkg::*; ();
	logic valid;
	logic ready;
	logic [2:0] opcode;
	logic [IDXW-1:0] index;
	logic signed [31:0] x_value;
	logic signed [31:0] y_value;
	modport source(output valid, opcode, index, x_value, y_value, input ready);
	modport sink(input valid, opcode, index, x_value, y_value, output ready);
endinterface

interface pcc_rsp_if ();
	logic valid;
	logic ready;
	logic [7:0] captured_beads;
	logic [7:0] beads_with_one;
	logic [7:0] beads_with_two;
	logic [7:0] beads_with_three;
	logic [7:0] beads_with_four;
	modport source(output valid, captured_beads, beads_with_one, beads_with_two,
		beads_with_three, beads_with_four, input ready);
	modport sink(input valid, captured_beads, beads_with_one, beads_with_two,
		beads_with_three, beads_with_four, output ready);
endinterface

@@ rtl/pcc_reach.sv @@
// ----------------------------------------------------------------------------
// pcc_reach
// Two-stage distance test: registered squares, then sum and compare.
// ----------------------------------------------------------------------------
module pcc_reach import pcc_pkg::*; (
	input logic clk,
	input logic signed [31:0] cx,
	input logic signed [31:0] cy,
	input logic signed [31:0] bx,
	input logic signed [31:0] by,
	input logic [62:0] dist_sq,
	output logic hit_s2
);
	logic signed [32:0] dx, dy;
	logic [31:0] ax, ay;
	logic ovf;
	logic [63:0] sqx_s1, sqy_s1;
	logic ovf_s1;
	logic [64:0] sum;

	// differences and magnitudes
	always_comb begin
		dx = 33'(cx) - 33'(bx);
		dy = 33'(cy) - 33'(by);
		ovf = (dx[32] != dx[31]) || (dy[32] != dy[31]);
		ax = dx[32] ? 32'(-dx) : dx[31:0];
		ay = dy[32] ? 32'(-dy) : dy[31:0];
	end

	// stage 1: squares
	always_ff @(posedge clk) begin
		sqx_s1 <= 64'(ax) * 64'(ax);
		sqy_s1 <= 64'(ay) * 64'(ay);
		ovf_s1 <= ovf;
	end

	// stage 2: compare, valid in the same cycle as the squares
	assign sum = 65'(sqx_s1) + 65'(sqy_s1);
	assign hit_s2 = !ovf_s1 && (sum < 65'(dist_sq));
endmodule

@@ rtl/pcc_core.sv @@
// ----------------------------------------------------------------------------
// pcc_core
// Position and count memories with the sequencer that runs all opcodes.
// ----------------------------------------------------------------------------
module pcc_core import pcc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [62:0] dist_sq,
	input logic start,
	input cmd_t cmd,
	input logic hold,
	output logic busy,
	output logic done,
	output rsp_t rsp
);
	typedef enum logic [2:0] {
		S_IDLE, S_MOVE, S_CHECK, S_UPD, S_TALLY, S_DONE
	} state_t;

	// memories: positions packed as {x,y}, counts
	logic [63:0] cell_mem [CELLS];
	logic [63:0] bead_mem [BEADS];
	logic [7:0] cnt_mem [BEADS];
	logic [CELLS-1:0] cell_act_q;
	logic [BEADS-1:0] bead_act_q;
	logic [BEADS-1:0] cnt_vld_q;

	state_t state_q;
	cmd_t cmd_q;
	logic [CW-1:0] c_q;
	logic [BW:0] b_q;
	logic [BW-1:0] b_s1, b_s2;
	logic v_s1, v_s2;
	logic [63:0] cell_rd_q, bead_rd_q;
	logic [7:0] cnt_rd_q;
	logic [7:0] total_q;
	logic [7:0] t1_q, t2_q, t3_q, t4_q;
	logic hit_s2;
	logic cell_we, bead_we, cnt_we;
	logic [CW-1:0] cell_wa, cell_ra;
	logic [BW-1:0] bead_wa, bead_ra, cnt_wa, cnt_ra;
	logic [63:0] cell_wd, bead_wd;
	logic [7:0] cnt_wd, cnt_cur, new_cnt;
	logic idx_cell_ok, idx_bead_ok;
	logic [BW-1:0] bsel;

	assign idx_cell_ok = 32'(cmd_q.index) < 32'(CELLS);
	assign idx_bead_ok = 32'(cmd_q.index) < 32'(BEADS);
	assign bsel = b_q[BW-1:0];
	assign cnt_cur = cnt_vld_q[b_s2] ? cnt_rd_q : 8'd0;
	assign new_cnt = sat_inc(cnt_cur);

	// read addresses; a move reads its entry on the accepting edge
	always_comb begin
		cell_ra = (state_q == S_CHECK) ? c_q
			: (state_q == S_IDLE) ? CW'(cmd.index) : CW'(cmd_q.index);
		bead_ra = (state_q == S_CHECK || state_q == S_TALLY) ? bsel
			: (state_q == S_IDLE) ? BW'(cmd.index) : BW'(cmd_q.index);
		cnt_ra = b_s1;
	end

	// write ports
	always_comb begin
		cell_we = 1'b0; bead_we = 1'b0; cnt_we = 1'b0;
		cell_wa = CW'(cmd_q.index); bead_wa = BW'(cmd_q.index);
		cnt_wa = b_s2; cnt_wd = new_cnt;
		cell_wd = {cmd_q.x_value, cmd_q.y_value};
		bead_wd = {cmd_q.x_value, cmd_q.y_value};
		unique case (state_q)
			S_IDLE: begin
				if (start && cmd.opcode == OP_LOAD_CELL && 32'(cmd.index) < 32'(CELLS)) begin
					cell_we = 1'b1; cell_wa = CW'(cmd.index);
					cell_wd = {cmd.x_value, cmd.y_value};
				end
				if (start && cmd.opcode == OP_LOAD_BEAD && 32'(cmd.index) < 32'(BEADS)) begin
					bead_we = 1'b1; bead_wa = BW'(cmd.index);
					bead_wd = {cmd.x_value, cmd.y_value};
				end
			end
			S_MOVE: begin
				cell_wd = {sat_add(cell_rd_q[63:32], cmd_q.x_value),
					sat_add(cell_rd_q[31:0], cmd_q.y_value)};
				bead_wd = {sat_add(bead_rd_q[63:32], cmd_q.x_value),
					sat_add(bead_rd_q[31:0], cmd_q.y_value)};
				// only an active entry moves
				cell_we = cmd_q.opcode == OP_MOVE_CELL && idx_cell_ok
					&& cell_act_q[CW'(cmd_q.index)];
				bead_we = cmd_q.opcode == OP_MOVE_BEAD && idx_bead_ok
					&& bead_act_q[BW'(cmd_q.index)];
			end
			S_CHECK, S_UPD: cnt_we = v_s2 && hit_s2 && cell_act_q[c_q];
			default: ;
		endcase
	end

	// memory arrays
	always_ff @(posedge clk) begin
		if (cell_we) cell_mem[cell_wa] <= cell_wd;
		if (bead_we) bead_mem[bead_wa] <= bead_wd;
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		cell_rd_q <= cell_mem[cell_ra];
		bead_rd_q <= bead_mem[bead_ra];
		cnt_rd_q <= cnt_mem[cnt_ra];
	end

	pcc_reach u_reach (
		.clk(clk), .cx(cell_rd_q[63:32]), .cy(cell_rd_q[31:0]),
		.bx(bead_rd_q[63:32]), .by(bead_rd_q[31:0]),
		.dist_sq(dist_sq), .hit_s2(hit_s2)
	);

	// sequencer: one pair a cycle; pipeline drains per cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; cmd_q <= '0; c_q <= '0; b_q <= '0;
			b_s1 <= '0; b_s2 <= '0; v_s1 <= 1'b0; v_s2 <= 1'b0;
			cell_act_q <= '0; bead_act_q <= '0; cnt_vld_q <= '0;
			total_q <= '0; t1_q <= '0; t2_q <= '0; t3_q <= '0; t4_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			// pair pipeline: s1 = memory read, s2 = squares and hit
			b_s1 <= bsel; b_s2 <= b_s1;
			v_s1 <= 1'b0; v_s2 <= v_s1;
			if (cnt_we) begin
				cell_act_q[c_q] <= 1'b0;
				cnt_vld_q[b_s2] <= 1'b1;
				if (new_cnt == 8'd1 && cnt_cur == 8'd0) total_q <= sat_inc(total_q);
			end
			unique case (state_q)
				S_IDLE: if (start) begin
					cmd_q <= cmd; b_q <= '0; c_q <= '0;
					t1_q <= '0; t2_q <= '0; t3_q <= '0; t4_q <= '0;
					priority case (cmd.opcode)
						OP_CLEAR: begin
							cnt_vld_q <= '0; total_q <= '0; state_q <= S_TALLY;
						end
						OP_LOAD_CELL: begin
							if (32'(cmd.index) < 32'(CELLS)) cell_act_q[CW'(cmd.index)] <= 1'b1;
							state_q <= S_TALLY;
						end
						OP_LOAD_BEAD: begin
							if (32'(cmd.index) < 32'(BEADS)) bead_act_q[BW'(cmd.index)] <= 1'b1;
							state_q <= S_TALLY;
						end
						OP_MOVE_CELL, OP_MOVE_BEAD: state_q <= S_MOVE;
						OP_CHECK: state_q <= S_CHECK;
						default: state_q <= S_TALLY;
					endcase
				end
				// read data is ready; the write port commits it
				S_MOVE: state_q <= S_TALLY;
				S_CHECK: begin
					if (32'(b_q) < 32'(BEADS)) begin
						v_s1 <= cell_act_q[c_q] && bead_act_q[bsel] && !cnt_we;
						b_q <= b_q + 1'b1;
					end else if (!v_s1 && !v_s2) begin
						b_q <= '0;
						if (32'(c_q) == 32'(CELLS - 1)) state_q <= S_TALLY;
						else c_q <= c_q + 1'b1;
					end
				end
				S_TALLY: begin
					if (32'(b_q) < 32'(BEADS) + 2) b_q <= b_q + 1'b1;
					else state_q <= S_DONE;
					if (v_s2 && cnt_vld_q[b_s2]) begin
						unique case (cnt_rd_q)
							8'd1: t1_q <= sat_inc(t1_q);
							8'd2: t2_q <= sat_inc(t2_q);
							8'd3: t3_q <= sat_inc(t3_q);
							8'd4: t4_q <= sat_inc(t4_q);
							default: ;
						endcase
					end
					v_s1 <= 32'(b_q) < 32'(BEADS);
				end
				// wait here while the result register is still full
				S_DONE: if (!hold) begin
					done <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign rsp = '{captured_beads: total_q, beads_with_one: t1_q,
		beads_with_two: t2_q, beads_with_three: t3_q, beads_with_four: t4_q};
endmodule

@@ rtl/pairwise_capture_check.sv @@
// A capture check takes one pair a cycle, pausing after each cell while
// the pair pipeline drains, on the cell and bead position-memory read
// ports. One command at a time; the result sits in an output register
// so the next command is taken meanwhile, and a command that finishes
// while that register is still full waits.
// Reset (arst_n low): flags, counts and dist_sq_q return to default.
// ----------------------------------------------------------------------------
// pairwise_capture_check
// Top level: command channel, result register and distance register.
// ----------------------------------------------------------------------------
`include "pairwise_capture_check_macros.svh"
module pairwise_capture_check import pcc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [62:0] cfg_wdata,
	pcc_cmd_if.sink cmd,
	pcc_rsp_if.source rsp
);
	logic [62:0] dist_sq_q;
	logic busy, done, start;
	logic rsp_hold;
	cmd_t cmd_beat;
	rsp_t core_rsp, rsp_q;
	logic rsp_valid_q;

	assign cmd.ready = !busy;
	assign start = cmd.valid && cmd.ready;
	assign cmd_beat = '{opcode: cmd.opcode, index: cmd.index,
		x_value: cmd.x_value, y_value: cmd.y_value};
	assign rsp_hold = rsp_valid_q && !rsp.ready;

	// distance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dist_sq_q <= DIST_SQ_RESET;
		else if (cfg_we) dist_sq_q <= cfg_wdata;
	end

	pcc_core u_core (
		.clk(clk), .arst_n(arst_n), .dist_sq(dist_sq_q), .start(start),
		.cmd(cmd_beat), .hold(rsp_hold), .busy(busy), .done(done), .rsp(core_rsp)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0; rsp_q <= '0;
		end else begin
			if (done) begin
				rsp_valid_q <= 1'b1; rsp_q <= core_rsp;
			end else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.captured_beads = rsp_q.captured_beads;
	assign rsp.beads_with_one = rsp_q.beads_with_one;
	assign rsp.beads_with_two = rsp_q.beads_with_two;
	assign rsp.beads_with_three = rsp_q.beads_with_three;
	assign rsp.beads_with_four = rsp_q.beads_with_four;

	`PCC_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy)
	`PCC_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`PCC_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_hold, rsp.valid && $stable(rsp_q))
endmodule
